@@ sv/dinic_pkg.sv @@
package dinic_pkg;

	localparam int DEF_MAX_NODES = 256;
	localparam int DEF_MAX_EDGES = 1024;
	localparam int DEF_CAP_BITS  = 32;

	localparam int NODE_W   = 8;
	localparam int CAP_IN_W = 32;
	localparam int LIMIT_W  = 42;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 10;
	localparam int NCNT_W   = 9;
	localparam int CMD_W    = 2;

	localparam logic [NCNT_W-1:0] NCNT_RESET = 9'd256;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_A,
		ST_ADD_B,
		ST_ADD_C,
		ST_ADD_D,
		ST_ITER,
		ST_BFS_INIT,
		ST_BFS_POP,
		ST_BFS_NODE,
		ST_BFS_FIRST,
		ST_BFS_EDGE,
		ST_BFS_VISIT,
		ST_DFS_START,
		ST_DFS_ENTER,
		ST_DFS_LOAD,
		ST_DFS_SCAN,
		ST_DFS_HEAD,
		ST_DFS_CHECK,
		ST_RET,
		ST_RET_LOAD,
		ST_RET_FWD,
		ST_RET_REV
	} state_t;

endpackage

@@ sv/dinic_max_flow_engine_unit.sv @@
// maximum flow engine (dinic): one command word in, one result word out
// clear: result straight from idle; add edge: result after states add_a, add_b, add_c, add_d
// run: length set by the graph; bfs edge visits, dfs edge probes and unwind steps all use
// the shared edge memories
// one command word at a time; in_ready is low while a command works or a result waits
// arst_n clears the sequencer, the node valid bits and the edge count; node_count resets to 256
module dinic_max_flow_engine_unit
	import dinic_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_EDGES = DEF_MAX_EDGES,
	parameter int CAP_BITS  = DEF_CAP_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [NCNT_W-1:0]   node_count,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [NODE_W-1:0]   from_node,
	input  logic [NODE_W-1:0]   to_node,
	input  logic [CAP_IN_W-1:0] capacity,
	input  logic [LIMIT_W-1:0]  flow_limit,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [POS_W-1:0]    edge_position,
	output logic [LIMIT_W-1:0]  flow_total
);

	// widths derived from the sizing parameters
	localparam int NB  = $clog2(MAX_NODES);        // node index
	localparam int EB  = $clog2(MAX_EDGES);        // edge slot index
	localparam int PW  = EB + 1;                   // edge pointer with null code
	localparam int UW  = $clog2(MAX_EDGES + 1);    // edge slot count
	localparam int CW  = $clog2(MAX_EDGES + 1);    // per-node edge count
	localparam int QW  = $clog2(MAX_NODES + 1);    // bfs queue pointers
	localparam int DB  = $clog2(MAX_NODES + 1);    // dfs depth
	localparam int LVW = NB + 1;                   // bfs level
	localparam int SW  = (CAP_BITS > LIMIT_W) ? CAP_BITS : LIMIT_W;
	localparam int XW  = 48;

	localparam logic [PW-1:0] NIL = '1;
	localparam logic [XW-1:0] CAP_MAX_X = (XW'(1) << CAP_BITS) - XW'(1);

	// control state
	state_t             st_q, st_d;
	logic               ovq_q, ovq_d;
	logic [NCNT_W-1:0]  ncnt_q;
	logic [UW-1:0]      used_q, used_d;
	logic [MAX_NODES-1:0] nv_q, nv_d;      // node list entry valid
	logic [MAX_NODES-1:0] cv_q, cv_d;      // current-edge pointer written this phase
	logic [MAX_NODES-1:0] rch_q, rch_d;    // reached by bfs
	logic [QW-1:0]      qh_q, qh_d, qt_q, qt_d;
	logic [DB-1:0]      depth_q, depth_d;

	// working payload registers
	logic [NB-1:0]       a_q, a_d, b_q, b_d, u_q, u_d, v_q, v_d;
	logic [CAP_BITS-1:0] cap_q, cap_d, r_q, r_d;
	logic [LIMIT_W-1:0]  lim_q, lim_d, total_q, total_d;
	logic [LIMIT_W-1:0]  need_q, need_d, got_q, got_d, ret_q, ret_d;
	logic [PW-1:0]       last_q, last_d, e_q, e_d, nx_q, nx_d;
	logic [LVW-1:0]      lu_q, lu_d;
	logic [EB-1:0]       pe_q, pe_d;
	logic [STATUS_W-1:0] stat_q, stat_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [LIMIT_W-1:0]  res_q, res_d;

	// memory ports
	logic                eh_we, er_we, en_we;
	logic [EB-1:0]       eh_wa, er_wa, en_wa, e_ra, er_ra, en_ra;
	logic [NB-1:0]       eh_wd, eh_rd;
	logic [CAP_BITS-1:0] er_wd, er_rd;
	logic [PW-1:0]       en_wd, en_rd;

	logic                nd_we;
	logic [NB-1:0]       nd_wa, nd_ra;
	logic                nf_we;
	logic [PW-1:0]       nf_wd, nf_rd, nl_wd, nl_rd;
	logic [CW-1:0]       nc_wd, nc_rd;

	logic                lv_we;
	logic [NB-1:0]       lv_wa, lv_ra;
	logic [LVW-1:0]      lv_wd, lv_rd;

	logic                ce_we;
	logic [NB-1:0]       ce_wa, ce_ra;
	logic [PW-1:0]       ce_wd, ce_rd;

	logic                bq_we;
	logic [NB-1:0]       bq_wa, bq_ra, bq_wd, bq_rd;

	logic                sk_we, ei_we;
	logic [DB-1:0]       sk_wa, sk_ra, ei_wa, ei_ra;
	logic [NB-1:0]       sn_rd;
	logic [LIMIT_W-1:0]  sneed_rd, sgot_rd;
	logic [EB-1:0]       ei_rd;

	// helpers
	logic [XW-1:0]       cap_x;
	logic [CAP_BITS-1:0] cap_sat;
	logic                a_ok, b_ok;
	logic [PW-1:0]       first_v, last_v;
	logic [CW-1:0]       cnt_v;
	logic [EB-1:0]       slot;
	logic [LIMIT_W-1:0]  room, new_need, got_sum;

	assign cfg_ready     = 1'b1;
	assign in_ready      = (st_q == ST_IDLE) && !ovq_q;
	assign out_valid     = ovq_q;
	assign status        = stat_q;
	assign edge_position = pos_q;
	assign flow_total    = res_q;

	// capacity saturates at the stored residual width
	assign cap_x   = XW'(capacity);
	assign cap_sat = (cap_x > CAP_MAX_X) ? CAP_BITS'(CAP_MAX_X) : CAP_BITS'(cap_x);

	// node indexes must be below node_count and the table size
	assign a_ok = (NCNT_W'(from_node) < ncnt_q) && (32'(from_node) < MAX_NODES);
	assign b_ok = (NCNT_W'(to_node) < ncnt_q) && (32'(to_node) < MAX_NODES);

	// node list entries read as empty until written
	always_comb begin
		logic [NB-1:0] idx;
		idx = (st_q == ST_ADD_C) ? b_q : ((st_q == ST_ADD_A) ? a_q : u_q);
		first_v = nv_q[idx] ? nf_rd : NIL;
		last_v  = nv_q[idx] ? nl_rd : NIL;
		cnt_v   = nv_q[idx] ? nc_rd : '0;
	end

	assign slot     = EB'(used_q);
	assign room     = need_q - got_q;
	assign new_need = (SW'(room) < SW'(r_q)) ? room : LIMIT_W'(r_q);
	assign got_sum  = got_q + ret_q;

	// sequencer: edge add, bfs, dfs and unwind steps
	always_comb begin
		st_d    = st_q;
		ovq_d   = ovq_q;
		used_d  = used_q;
		nv_d    = nv_q;
		cv_d    = cv_q;
		rch_d   = rch_q;
		qh_d    = qh_q;
		qt_d    = qt_q;
		depth_d = depth_q;
		a_d     = a_q;
		b_d     = b_q;
		u_d     = u_q;
		v_d     = v_q;
		cap_d   = cap_q;
		r_d     = r_q;
		lim_d   = lim_q;
		total_d = total_q;
		need_d  = need_q;
		got_d   = got_q;
		ret_d   = ret_q;
		last_d  = last_q;
		e_d     = e_q;
		nx_d    = nx_q;
		lu_d    = lu_q;
		pe_d    = pe_q;
		stat_d  = stat_q;
		pos_d   = pos_q;
		res_d   = res_q;

		eh_we = 1'b0; eh_wa = slot; eh_wd = a_q;
		er_we = 1'b0; er_wa = slot; er_wd = cap_q;
		en_we = 1'b0; en_wa = slot; en_wd = NIL;
		e_ra  = e_q[EB-1:0]; er_ra = e_q[EB-1:0]; en_ra = e_q[EB-1:0];
		nd_we = 1'b0; nd_wa = a_q; nd_ra = u_q;
		nf_we = 1'b0; nf_wd = PW'(slot); nl_wd = PW'(slot); nc_wd = '0;
		lv_we = 1'b0; lv_wa = a_q; lv_wd = '0; lv_ra = u_q;
		ce_we = 1'b0; ce_wa = u_q; ce_wd = NIL; ce_ra = u_q;
		bq_we = 1'b0; bq_wa = qt_q[NB-1:0]; bq_wd = a_q; bq_ra = qh_q[NB-1:0];
		sk_we = 1'b0; sk_wa = depth_q; sk_ra = depth_q;
		ei_we = 1'b0; ei_wa = depth_q + DB'(1); ei_ra = depth_q;

		if (ovq_q && out_ready) begin
			ovq_d = 1'b0;
		end

		case (st_q)
			ST_IDLE: begin
				nd_ra = NB'(from_node);
				if (in_valid && in_ready) begin
					a_d    = NB'(from_node);
					b_d    = NB'(to_node);
					cap_d  = cap_sat;
					lim_d  = flow_limit;
					stat_d = STAT_OK;
					pos_d  = '0;
					res_d  = '0;
					case (command)
						CMD_CLEAR: begin
							nv_d   = '0;
							used_d = '0;
							ovq_d  = 1'b1;
						end
						CMD_ADD: begin
							if (!a_ok || !b_ok) begin
								stat_d = STAT_RANGE;
								ovq_d  = 1'b1;
							end else if (32'(used_q) + 2 > MAX_EDGES) begin
								stat_d = STAT_FULL;
								ovq_d  = 1'b1;
							end else begin
								st_d = ST_ADD_A;
							end
						end
						CMD_RUN: begin
							if (!a_ok || !b_ok) begin
								stat_d = STAT_RANGE;
								ovq_d  = 1'b1;
							end else begin
								total_d = '0;
								st_d    = ST_ITER;
							end
						end
						default: begin
							ovq_d = 1'b1;
						end
					endcase
				end
			end

			// forward slot into the tail's list
			ST_ADD_A: begin
				pos_d  = POS_W'(cnt_v);
				last_d = last_v;
				eh_we  = 1'b1; eh_wa = slot; eh_wd = b_q;
				er_we  = 1'b1; er_wa = slot; er_wd = cap_q;
				en_we  = 1'b1; en_wa = slot; en_wd = NIL;
				nd_we  = 1'b1; nd_wa = a_q;
				nf_we  = (last_v == NIL);
				nf_wd  = PW'(slot);
				nl_wd  = PW'(slot);
				nc_wd  = cnt_v + CW'(1);
				nv_d[a_q] = 1'b1;
				st_d   = ST_ADD_B;
			end
			ST_ADD_B: begin
				en_we = (last_q != NIL);
				en_wa = last_q[EB-1:0];
				en_wd = PW'(slot);
				nd_ra = b_q;
				st_d  = ST_ADD_C;
			end
			// reverse twin into the head's list
			ST_ADD_C: begin
				last_d = last_v;
				eh_we  = 1'b1; eh_wa = slot | EB'(1); eh_wd = a_q;
				er_we  = 1'b1; er_wa = slot | EB'(1); er_wd = '0;
				en_we  = 1'b1; en_wa = slot | EB'(1); en_wd = NIL;
				nd_we  = 1'b1; nd_wa = b_q;
				nf_we  = (last_v == NIL);
				nf_wd  = PW'(slot | EB'(1));
				nl_wd  = PW'(slot | EB'(1));
				nc_wd  = cnt_v + CW'(1);
				nv_d[b_q] = 1'b1;
				st_d   = ST_ADD_D;
			end
			ST_ADD_D: begin
				en_we  = (last_q != NIL);
				en_wa  = last_q[EB-1:0];
				en_wd  = PW'(slot | EB'(1));
				used_d = used_q + UW'(2);
				ovq_d  = 1'b1;
				st_d   = ST_IDLE;
			end

			// next phase while the limit is not met
			ST_ITER: begin
				if (total_q < lim_q) begin
					st_d = ST_BFS_INIT;
				end else begin
					res_d = total_q;
					ovq_d = 1'b1;
					st_d  = ST_IDLE;
				end
			end

			ST_BFS_INIT: begin
				rch_d      = '0;
				rch_d[a_q] = 1'b1;
				lv_we = 1'b1; lv_wa = a_q; lv_wd = '0;
				bq_we = 1'b1; bq_wa = '0; bq_wd = a_q;
				qh_d  = '0;
				qt_d  = QW'(1);
				st_d  = ST_BFS_POP;
			end
			ST_BFS_POP: begin
				if (qh_q < qt_q) begin
					bq_ra = qh_q[NB-1:0];
					qh_d  = qh_q + QW'(1);
					st_d  = ST_BFS_NODE;
				end else if (rch_q[b_q]) begin
					st_d = ST_DFS_START;
				end else begin
					res_d = total_q;
					ovq_d = 1'b1;
					st_d  = ST_IDLE;
				end
			end
			ST_BFS_NODE: begin
				u_d   = bq_rd;
				nd_ra = bq_rd;
				lv_ra = bq_rd;
				st_d  = ST_BFS_FIRST;
			end
			ST_BFS_FIRST: begin
				lu_d = lv_rd;
				e_d  = first_v;
				st_d = ST_BFS_EDGE;
			end
			ST_BFS_EDGE: begin
				if (e_q == NIL) begin
					st_d = ST_BFS_POP;
				end else begin
					st_d = ST_BFS_VISIT;
				end
			end
			ST_BFS_VISIT: begin
				if ((er_rd != '0) && !rch_q[eh_rd] && (qt_q < QW'(MAX_NODES))) begin
					rch_d[eh_rd] = 1'b1;
					lv_we = 1'b1; lv_wa = eh_rd; lv_wd = lu_q + LVW'(1);
					bq_we = 1'b1; bq_wa = qt_q[NB-1:0]; bq_wd = eh_rd;
					qt_d  = qt_q + QW'(1);
				end
				e_d  = en_rd;
				st_d = ST_BFS_EDGE;
			end

			ST_DFS_START: begin
				cv_d    = '0;
				depth_d = '0;
				u_d     = a_q;
				need_d  = lim_q - total_q;
				got_d   = '0;
				st_d    = ST_DFS_ENTER;
			end
			ST_DFS_ENTER: begin
				if (u_q == b_q) begin
					ret_d = need_q;
					st_d  = ST_RET;
				end else begin
					st_d = ST_DFS_LOAD;
				end
			end
			ST_DFS_LOAD: begin
				lu_d = lv_rd;
				e_d  = cv_q[u_q] ? ce_rd : first_v;
				st_d = ST_DFS_SCAN;
			end
			ST_DFS_SCAN: begin
				if (e_q == NIL) begin
					ce_we = 1'b1; ce_wa = u_q; ce_wd = NIL;
					cv_d[u_q] = 1'b1;
					ret_d = got_q;
					st_d  = ST_RET;
				end else begin
					st_d = ST_DFS_HEAD;
				end
			end
			ST_DFS_HEAD: begin
				v_d   = eh_rd;
				r_d   = er_rd;
				nx_d  = en_rd;
				lv_ra = eh_rd;
				st_d  = ST_DFS_CHECK;
			end
			// edge usable if it has room and climbs exactly one level
			ST_DFS_CHECK: begin
				if ((r_q != '0) && rch_q[v_q] && (lv_rd == lu_q + LVW'(1)) &&
						(depth_q < DB'(MAX_NODES))) begin
					ce_we = 1'b1; ce_wa = u_q; ce_wd = e_q;
					cv_d[u_q] = 1'b1;
					sk_we = 1'b1; sk_wa = depth_q;
					ei_we = 1'b1; ei_wa = depth_q + DB'(1);
					depth_d = depth_q + DB'(1);
					u_d     = v_q;
					need_d  = new_need;
					got_d   = '0;
					st_d    = ST_DFS_ENTER;
				end else begin
					e_d  = nx_q;
					st_d = ST_DFS_SCAN;
				end
			end

			// hand the returned amount to the parent frame
			ST_RET: begin
				if (depth_q == '0) begin
					total_d = total_q + ret_q;
					st_d    = ST_ITER;
				end else begin
					ei_ra   = depth_q;
					sk_ra   = depth_q - DB'(1);
					depth_d = depth_q - DB'(1);
					st_d    = ST_RET_LOAD;
				end
			end
			ST_RET_LOAD: begin
				pe_d   = ei_rd;
				u_d    = sn_rd;
				need_d = sneed_rd;
				got_d  = sgot_rd;
				er_ra  = ei_rd;
				st_d   = ST_RET_FWD;
			end
			ST_RET_FWD: begin
				er_we = 1'b1; er_wa = pe_q;
				er_wd = CAP_BITS'(SW'(er_rd) - SW'(ret_q));
				er_ra = pe_q ^ EB'(1);
				en_ra = pe_q;
				st_d  = ST_RET_REV;
			end
			ST_RET_REV: begin
				er_we = 1'b1; er_wa = pe_q ^ EB'(1);
				er_wd = CAP_BITS'(SW'(er_rd) + SW'(ret_q));
				got_d = got_sum;
				if (got_sum == need_q) begin
					ret_d = got_sum;
					st_d  = ST_RET;
				end else begin
					ce_we = 1'b1; ce_wa = u_q; ce_wd = en_rd;
					cv_d[u_q] = 1'b1;
					st_d = ST_DFS_ENTER;
				end
			end

			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ovq_q   <= 1'b0;
			ncnt_q  <= NCNT_RESET;
			used_q  <= '0;
			nv_q    <= '0;
			cv_q    <= '0;
			rch_q   <= '0;
			qh_q    <= '0;
			qt_q    <= '0;
			depth_q <= '0;
		end else begin
			st_q    <= st_d;
			ovq_q   <= ovq_d;
			used_q  <= used_d;
			nv_q    <= nv_d;
			cv_q    <= cv_d;
			rch_q   <= rch_d;
			qh_q    <= qh_d;
			qt_q    <= qt_d;
			depth_q <= depth_d;
			if (cfg_valid && cfg_ready) begin
				ncnt_q <= node_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q     <= a_d;
		b_q     <= b_d;
		u_q     <= u_d;
		v_q     <= v_d;
		cap_q   <= cap_d;
		r_q     <= r_d;
		lim_q   <= lim_d;
		total_q <= total_d;
		need_q  <= need_d;
		got_q   <= got_d;
		ret_q   <= ret_d;
		last_q  <= last_d;
		e_q     <= e_d;
		nx_q    <= nx_d;
		lu_q    <= lu_d;
		pe_q    <= pe_d;
		stat_q  <= stat_d;
		pos_q   <= pos_d;
		res_q   <= res_d;
	end

	// edge table
	dinic_ram #(.WIDTH(NB), .DEPTH(MAX_EDGES)) u_edge_head (
		.clk(clk), .we(eh_we), .waddr(eh_wa), .wdata(eh_wd), .raddr(e_ra), .rdata(eh_rd)
	);
	dinic_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_EDGES)) u_edge_res (
		.clk(clk), .we(er_we), .waddr(er_wa), .wdata(er_wd), .raddr(er_ra), .rdata(er_rd)
	);
	dinic_ram #(.WIDTH(PW), .DEPTH(MAX_EDGES)) u_edge_next (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(en_ra), .rdata(en_rd)
	);

	// per-node list heads, tails and counts
	dinic_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_node_first (
		.clk(clk), .we(nd_we && nf_we), .waddr(nd_wa), .wdata(nf_wd), .raddr(nd_ra),
		.rdata(nf_rd)
	);
	dinic_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_node_last (
		.clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nl_wd), .raddr(nd_ra), .rdata(nl_rd)
	);
	dinic_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_node_cnt (
		.clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nc_wd), .raddr(nd_ra), .rdata(nc_rd)
	);

	// run scratch
	dinic_ram #(.WIDTH(LVW), .DEPTH(MAX_NODES)) u_level (
		.clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd)
	);
	dinic_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_cur_edge (
		.clk(clk), .we(ce_we), .waddr(ce_wa), .wdata(ce_wd), .raddr(ce_ra), .rdata(ce_rd)
	);
	dinic_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_bfs_queue (
		.clk(clk), .we(bq_we), .waddr(bq_wa), .wdata(bq_wd), .raddr(bq_ra), .rdata(bq_rd)
	);

	// dfs frame stack: parent node, need and got, and the edge into each frame
	dinic_ram #(.WIDTH(NB), .DEPTH(MAX_NODES + 1)) u_stk_node (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(u_q), .raddr(sk_ra), .rdata(sn_rd)
	);
	dinic_ram #(.WIDTH(LIMIT_W), .DEPTH(MAX_NODES + 1)) u_stk_need (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(need_q), .raddr(sk_ra), .rdata(sneed_rd)
	);
	dinic_ram #(.WIDTH(LIMIT_W), .DEPTH(MAX_NODES + 1)) u_stk_got (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(got_q), .raddr(sk_ra), .rdata(sgot_rd)
	);
	dinic_ram #(.WIDTH(EB), .DEPTH(MAX_NODES + 1)) u_stk_edge (
		.clk(clk), .we(ei_we), .waddr(ei_wa), .wdata(e_q[EB-1:0]), .raddr(ei_ra),
		.rdata(ei_rd)
	);

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (st_q == ST_IDLE))
		else $error("input ready outside idle");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DB'(MAX_NODES))
		else $error("dfs depth beyond node count");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE && st_q != ST_ITER && st_q != ST_BFS_INIT) |-> (qh_q <= qt_q))
		else $error("bfs queue head passed tail");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(used_q) <= MAX_EDGES) && !used_q[0])
		else $error("edge slot count invalid");
	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ITER) |-> (total_q <= lim_q))
		else $error("flow total above limit");
`endif

endmodule

@@ sv/dinic_ram.sv @@
module dinic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import dinic_pkg::*;

	// command code the block leaves unused: no effect, all-zero result
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int NIL = -1;
	localparam int NODES = DEF_MAX_NODES;
	localparam int EDGES = DEF_MAX_EDGES;
	localparam longint unsigned CAP_MAX = (64'd1 << DEF_CAP_BITS) - 1;
	localparam logic [LIMIT_W-1:0] LIMIT_ALL = '1;

	typedef enum logic [1:0] {K_WORD, K_CFG, K_HOLD} job_kind_t;

	typedef struct {
		job_kind_t            kind;
		logic [CMD_W-1:0]     cmd;
		logic [NODE_W-1:0]    src;
		logic [NODE_W-1:0]    dst;
		logic [CAP_IN_W-1:0]  cap;
		logic [LIMIT_W-1:0]   lim;
		logic [NCNT_W-1:0]    ncnt;
	} job_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    pos;
		logic [LIMIT_W-1:0]  total;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [NCNT_W-1:0]   node_count = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command = '0;
	logic [NODE_W-1:0]   from_node = '0;
	logic [NODE_W-1:0]   to_node = '0;
	logic [CAP_IN_W-1:0] capacity = '0;
	logic [LIMIT_W-1:0]  flow_limit = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    edge_position;
	logic [LIMIT_W-1:0]  flow_total;

	dinic_max_flow_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .node_count(node_count),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .from_node(from_node), .to_node(to_node),
		.capacity(capacity), .flow_limit(flow_limit),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .edge_position(edge_position), .flow_total(flow_total)
	);

	always #5 clk = ~clk;

	// shadow graph: edge table, node lists, run scratch
	int              g_head [EDGES];
	int              g_next [EDGES];
	longint unsigned g_res  [EDGES];
	int              g_first[NODES];
	int              g_last [NODES];
	int              g_deg  [NODES];
	int              g_used;
	int              g_ncnt;
	int              lvl    [NODES];
	bit              seen   [NODES];
	int              cursor [NODES];
	int              bq     [NODES];
	int              f_edge [NODES+1];
	int              f_node [NODES+1];
	longint unsigned f_need [NODES+1];
	longint unsigned f_got  [NODES+1];

	job_t    pending[$];
	answer_t flow_answers[$];
	int      errors = 0;
	int      n_words = 0, n_runs = 0, n_adds = 0, n_cfg = 0, n_results = 0;
	bit      in_taken = 0, cfg_taken = 0;
	int      gap = 0, stall = 0, quiet = 0;

	function automatic void wipe_graph();
		for (int i = 0; i < NODES; i++) begin
			g_first[i] = NIL;
			g_last[i] = NIL;
			g_deg[i] = 0;
		end
		g_used = 0;
	endfunction

	function automatic void link_slot(int slot, int tail, int head, longint unsigned r);
		g_head[slot] = head;
		g_res[slot] = r;
		g_next[slot] = NIL;
		if (g_last[tail] == NIL)
			g_first[tail] = slot;
		else
			g_next[g_last[tail]] = slot;
		g_last[tail] = slot;
		g_deg[tail]++;
	endfunction

	// bfs over edges with residual left; true when the sink is reached
	function automatic bit layer_graph(int s, int t);
		int qh, qt, u, e, v;
		qh = 0;
		qt = 0;
		for (int i = 0; i < NODES; i++) seen[i] = 0;
		seen[s] = 1;
		lvl[s] = 0;
		bq[qt++] = s;
		while (qh < qt) begin
			u = bq[qh++];
			for (e = g_first[u]; e != NIL; e = g_next[e]) begin
				v = g_head[e];
				if (g_res[e] > 0 && !seen[v] && qt < NODES) begin
					seen[v] = 1;
					lvl[v] = lvl[u] + 1;
					bq[qt++] = v;
				end
			end
		end
		return seen[t];
	endfunction

	// one blocking flow with per-node cursors and an explicit frame stack
	function automatic longint unsigned blocking_push(int s, int t, longint unsigned need);
		int d, u, e, v, pe, pu;
		longint unsigned ret, room;
		bit unwinding;
		d = 0;
		f_node[0] = s;
		f_need[0] = need;
		f_got[0] = 0;
		forever begin
			u = f_node[d];
			unwinding = 1;
			if (u == t) begin
				ret = f_need[d];
			end else begin
				e = cursor[u];
				while (e != NIL) begin
					v = g_head[e];
					if (g_res[e] > 0 && seen[v] && lvl[v] == lvl[u] + 1 && d < NODES)
						break;
					e = g_next[e];
				end
				cursor[u] = e;
				if (e != NIL) begin
					room = f_need[d] - f_got[d];
					d++;
					f_edge[d] = e;
					f_node[d] = g_head[e];
					f_need[d] = room < g_res[e] ? room : g_res[e];
					f_got[d] = 0;
					unwinding = 0;
				end else begin
					ret = f_got[d];
				end
			end
			while (unwinding) begin
				if (d == 0)
					return ret;
				pe = f_edge[d];
				d--;
				pu = f_node[d];
				g_res[pe] -= ret;
				g_res[pe ^ 1] += ret;
				f_got[d] += ret;
				if (f_got[d] == f_need[d]) begin
					ret = f_got[d];
				end else begin
					cursor[pu] = g_next[pe];
					unwinding = 0;
				end
			end
		end
	endfunction

	function automatic answer_t predict_word(job_t j);
		answer_t a;
		int n;
		longint unsigned total, lim, cap;
		a = '{default: '0};
		n = g_ncnt < NODES ? g_ncnt : NODES;
		lim = j.lim;
		cap = j.cap;
		case (j.cmd)
			CMD_CLEAR: wipe_graph();
			CMD_ADD: begin
				if (j.src >= n || j.dst >= n) begin
					a.status = STAT_RANGE;
				end else if (g_used + 2 > EDGES) begin
					a.status = STAT_FULL;
				end else begin
					if (cap > CAP_MAX) cap = CAP_MAX;
					a.pos = POS_W'(g_deg[j.src]);
					link_slot(g_used, j.src, j.dst, cap);
					link_slot(g_used + 1, j.dst, j.src, 0);
					g_used += 2;
				end
			end
			CMD_RUN: begin
				if (j.src >= n || j.dst >= n) begin
					a.status = STAT_RANGE;
				end else begin
					total = 0;
					while (total < lim && layer_graph(j.src, j.dst)) begin
						for (int i = 0; i < NODES; i++) cursor[i] = g_first[i];
						total += blocking_push(j.src, j.dst, lim - total);
					end
					a.total = LIMIT_W'(total);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic push_word(logic [CMD_W-1:0] c, int s, int d, logic [CAP_IN_W-1:0] cp,
			logic [LIMIT_W-1:0] l);
		job_t j;
		j = '{kind: K_WORD, cmd: c, src: NODE_W'(s), dst: NODE_W'(d), cap: cp, lim: l,
			ncnt: '0};
		pending = {pending, j};
	endtask

	task automatic push_cfg(logic [NCNT_W-1:0] v);
		job_t j;
		j = '{kind: K_CFG, cmd: CMD_CLEAR, src: 0, dst: 0, cap: 0, lim: 0, ncnt: v};
		pending = {pending, j};
	endtask

	task automatic push_hold();
		job_t j;
		j = '{kind: K_HOLD, cmd: CMD_CLEAR, src: 0, dst: 0, cap: 0, lim: 0, ncnt: 0};
		pending = {pending, j};
	endtask

	function automatic logic [LIMIT_W-1:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LIMIT_ALL;
			2: return LIMIT_W'($urandom_range(1, 50));
			3: return LIMIT_W'($urandom_range(1, 100000));
			default: return LIMIT_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [CAP_IN_W-1:0] rand_cap();
		case ($urandom_range(0, 4))
			0: return '1;
			1: return '0;
			2: return $urandom_range(1, 20);
			default: return $urandom;
		endcase
	endfunction

	// accept side: predict on the accepting edge, apply config writes
	always @(posedge clk) begin
		job_t j;
		if (arst_n && in_valid && in_ready) begin
			j = '{kind: K_WORD, cmd: command, src: from_node, dst: to_node,
				cap: capacity, lim: flow_limit, ncnt: '0};
			flow_answers = {flow_answers, predict_word(j)};
			n_words++;
			if (command == CMD_RUN) n_runs++;
			if (command == CMD_ADD) n_adds++;
			in_taken = 1;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			g_ncnt = node_count;
			n_cfg++;
			cfg_taken = 1;
		end
	end

	// result checker: oldest expectation first
	always @(posedge clk) begin
		answer_t w;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (flow_answers.size() == 0) begin
				$display("tb: result word with nothing expected at %0t", $realtime);
				errors++;
			end else begin
				w = flow_answers.pop_front();
				if (status !== w.status) report("status", status, w.status);
				if (edge_position !== w.pos) report("edge_position", edge_position, w.pos);
				if (flow_total !== w.total) report("flow_total", flow_total, w.total);
			end
		end
	end

	// word and config driver, changes on the falling edge
	always @(negedge clk) begin
		bit nv_in, nv_cfg, calm;
		job_t j;
		calm = pending.size() < 15;
		nv_in = in_valid;
		nv_cfg = cfg_valid;
		if (in_taken) begin
			in_taken = 0;
			nv_in = 0;
			if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
		end
		if (cfg_taken) begin
			cfg_taken = 0;
			nv_cfg = 0;
		end
		// block is idle once nothing is owed and nothing is on offer
		if (arst_n && flow_answers.size() == 0 && !nv_in && !nv_cfg && !in_valid)
			quiet++;
		else
			quiet = 0;
		if (arst_n && !nv_in && !nv_cfg) begin
			if (gap > 0) begin
				gap--;
			end else if (pending.size() > 0) begin
				j = pending[0];
				case (j.kind)
					K_WORD: begin
						void'(pending.pop_front());
						command <= j.cmd;
						from_node <= j.src;
						to_node <= j.dst;
						capacity <= j.cap;
						flow_limit <= j.lim;
						nv_in = 1;
					end
					K_CFG: if (quiet >= 6) begin
						void'(pending.pop_front());
						node_count <= j.ncnt;
						nv_cfg = 1;
					end
					K_HOLD: if (quiet >= 6) void'(pending.pop_front());
					default: ;
				endcase
			end
		end
		in_valid <= nv_in;
		cfg_valid <= nv_cfg;
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		bit rdy;
		if (!arst_n || pending.size() < 15) begin
			rdy = arst_n;
			stall = 0;
		end else if (stall > 0) begin
			stall--;
			rdy = 0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall = $urandom_range(1, 17) - 1;
			rdy = 0;
		end else begin
			rdy = 1;
		end
		out_ready <= rdy;
	end

	initial begin
		int nodes, span, k;
		g_ncnt = NCNT_RESET;
		wipe_graph();

		// directed: extremes, special cases, every command
		push_cfg(9'd256);
		push_word(CMD_ADD, 0, 255, '1, 0);
		push_word(CMD_ADD, 0, 1, 0, 0);
		push_word(CMD_ADD, 0, 0, 5, 0);
		push_word(CMD_ADD, 1, 255, 7, 0);
		push_word(CMD_ADD, 0, 1, 9, 0);
		push_word(CMD_RUN, 0, 255, 3, LIMIT_ALL);
		push_word(CMD_RUN, 0, 255, 0, LIMIT_ALL);
		push_word(CMD_RUN, 0, 0, 0, 42'd1234);
		push_word(CMD_RUN, 255, 0, 0, 0);
		push_word(CMD_RUN, 255, 0, 0, LIMIT_ALL);
		push_word(CMD_SPARE, 8'hff, 8'hff, '1, LIMIT_ALL);
		push_cfg(9'd8);
		push_word(CMD_ADD, 8, 0, 1, 0);
		push_word(CMD_ADD, 0, 9, 1, 0);
		push_word(CMD_RUN, 0, 200, 0, 10);
		push_word(CMD_RUN, 0, 1, 0, LIMIT_ALL);
		push_cfg(9'd0);
		push_word(CMD_ADD, 0, 0, 1, 0);
		push_word(CMD_RUN, 0, 0, 0, 5);
		push_cfg(9'd511);
		push_word(CMD_ADD, 255, 254, 3, 0);
		push_cfg(9'd1);
		push_word(CMD_RUN, 0, 0, 0, LIMIT_ALL);
		push_hold();
		// clear, a small run, then a range check on a shrunk node count
		push_cfg(9'd256);
		push_word(CMD_CLEAR, 0, 0, 0, 0);
		push_word(CMD_ADD, 3, 4, 1, 0);
		push_word(CMD_RUN, 0, 3, 0, LIMIT_ALL);
		push_cfg(9'd4);
		push_word(CMD_ADD, 9, 0, 1, 0);
		push_word(CMD_CLEAR, 0, 0, 0, 0);

		// random graphs: mostly small and well formed, runs on top
		k = 0;
		while (k < 96) begin
			case ($urandom_range(0, 5))
				0: nodes = 256;
				1: nodes = 511;
				default: nodes = $urandom_range(2, 12);
			endcase
			push_cfg(NCNT_W'(nodes));
			push_word(CMD_CLEAR, $urandom, $urandom, $urandom,
				LIMIT_W'({$urandom, $urandom}));
			span = nodes > 256 ? 256 : nodes;
			if (span > 16 && $urandom_range(0, 1)) span = 16;
			repeat ($urandom_range(3, 15)) begin
				if ($urandom_range(0, 9) == 0)
					push_word(CMD_ADD, $urandom, $urandom, rand_cap(),
						LIMIT_W'({$urandom, $urandom}));
				else
					push_word(CMD_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
						rand_cap(), LIMIT_W'({$urandom, $urandom}));
				k++;
			end
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 9))
					0: push_word(CMD_SPARE, $urandom, $urandom, $urandom,
						LIMIT_W'({$urandom, $urandom}));
					1: push_word(CMD_RUN, $urandom, $urandom, $urandom, rand_limit());
					default: push_word(CMD_RUN, $urandom_range(0, span - 1),
						$urandom_range(0, span - 1), $urandom, rand_limit());
				endcase
				k++;
			end
			if ($urandom_range(0, 3) == 0) push_hold();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending.size() == 0 && !in_valid && !cfg_valid && flow_answers.size() == 0);
		repeat (50) @(posedge clk);
		$display("tb: %0d words (%0d edge adds, %0d flow runs), %0d results, %0d node count writes",
			n_words, n_adds, n_runs, n_results, n_cfg);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#200_000_000;
		$display("tb: timeout");
		$display("tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
sv/dinic_pkg.sv
sv/dinic_ram.sv
sv/dinic_max_flow_engine_unit.sv
tb/tb.sv
